>>> rtl/cqt_pkg.sv
`timescale 1ns / 1ps

package cqt_pkg;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_QUERY   = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  localparam logic [1:0] CFG_WINDOW   = 2'd0;
  localparam logic [1:0] CFG_MIN      = 2'd1;
  localparam logic [1:0] CFG_DEGRADED = 2'd2;

  localparam logic [15:0] WINDOW_RST   = 16'd60;
  localparam logic [15:0] MIN_RST      = 16'd20;
  localparam logic [6:0]  DEGRADED_RST = 7'd20;

  localparam logic [7:0] PERCENT_NONE = 8'hFF;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    op_e         op;
    logic [7:0]  channel;
    logic        retry;
    logic        fcs_error;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  channel;
    logic [31:0] frames;
    logic [31:0] retries;
    logic [31:0] fcs_errors;
    logic [31:0] win_open;
    logic [31:0] seen_at;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic [31:0] frame_count;
    logic [7:0]  retry_percent;
    logic [7:0]  fcs_error_percent;
    logic        degraded;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_MISS,
    ST_ROLL,
    ST_COUNT,
    ST_QWRITE,
    ST_DIV_R,
    ST_DIV_F,
    ST_RESULT
  } state_e;

endpackage

>>> rtl/cqt_ram.sv
`timescale 1ns / 1ps

module cqt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/cqt_fifo.sv
`timescale 1ns / 1ps

module cqt_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  logic [Width-1:0] slot_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> rtl/cqt_div.sv
`timescale 1ns / 1ps

module cqt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] hits_i,
  input  logic [31:0] frames_i,
  output logic        done_o,
  output logic [6:0]  quot_o
);

  logic [38:0] rem_q;
  logic [31:0] div_q;
  logic [2:0]  cnt_q;
  logic        busy_q;
  logic [38:0] trial;
  logic        take;

  // hits never exceed frames, so the quotient fits seven bits
  assign trial = {7'd0, div_q} << cnt_q;
  assign take  = (rem_q >= trial);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= ({7'd0, hits_i} << 6) + ({7'd0, hits_i} << 5) + ({7'd0, hits_i} << 2);
      div_q <= frames_i;
    end else if (busy_q && take) begin
      rem_q <= rem_q - trial;
    end
    if (busy_q) begin
      quot_o <= {quot_o[5:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd6;
      end else if (busy_q) begin
        if (cnt_q == 3'd0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 3'd1;
        end
      end
    end
  end

endmodule

>>> rtl/cqt_front.sv
`timescale 1ns / 1ps

module cqt_front (
  input  logic         push_i,
  output logic         full_o,
  input  logic [1:0]   req_type_i,
  input  logic [7:0]   channel_i,
  input  logic         retry_flag_i,
  input  logic         fcs_error_flag_i,
  input  logic [31:0]  time_now_i,
  output logic         cmd_push_o,
  output cqt_pkg::cmd_t cmd_o,
  input  logic         cmd_full_i
);

  logic keep;

  // unused codes and observes of channel zero leave no trace
  always_comb begin
    case (cqt_pkg::op_e'(req_type_i))
      cqt_pkg::OP_OBSERVE: keep = (channel_i != 8'd0);
      cqt_pkg::OP_QUERY:   keep = 1'b1;
      cqt_pkg::OP_CLEAR:   keep = 1'b1;
      default:             keep = 1'b0;
    endcase
  end

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && keep;
  assign cmd_o = '{op: cqt_pkg::op_e'(req_type_i), channel: channel_i, retry: retry_flag_i,
                   fcs_error: fcs_error_flag_i, now: time_now_i};

endmodule

>>> rtl/cqt_back.sv
`timescale 1ns / 1ps

module cqt_back #(
  parameter int TableEntries = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      window_i,
  input  logic [15:0]      min_frames_i,
  input  logic [6:0]       degraded_i,
  input  logic             cmd_empty_i,
  input  cqt_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output cqt_pkg::result_t res_o
);

  localparam int AW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int UW = $clog2(TableEntries + 1);
  localparam int EW = $bits(cqt_pkg::entry_t);

  cqt_pkg::state_e  state_q, state_d;
  cqt_pkg::cmd_t    cmd_q, cmd_d;
  cqt_pkg::entry_t  ent_q, ent_d, rd_ent, wr_ent;
  cqt_pkg::result_t res_q, res_d;
  logic [UW-1:0]    used_q, used_d, idx_q, idx_d;
  logic [AW-1:0]    eidx_q, eidx_d, min_idx_q, min_idx_d;
  logic [31:0]      min_ls_q, min_ls_d;
  logic             we;
  logic [EW-1:0]    rdata;
  logic             div_start, div_done;
  logic [31:0]      div_hits;
  logic [6:0]       quot;
  logic             pct_ok;
  logic [31:0]      age;

  assign rd_ent = cqt_pkg::entry_t'(rdata);

  cqt_ram #(.Width(EW), .Depth(TableEntries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(eidx_q),
    .wdata_i(wr_ent),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  cqt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hits_i  (div_hits),
    .frames_i(ent_q.frames),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign pct_ok = (ent_q.frames >= {16'd0, min_frames_i}) && (ent_q.frames != 32'd0);
  assign age    = (cmd_q.now >= ent_q.win_open) ? cmd_q.now - ent_q.win_open : 32'd0;
  assign res_o  = res_q;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    ent_d     = ent_q;
    res_d     = res_q;
    used_d    = used_q;
    idx_d     = idx_q;
    eidx_d    = eidx_q;
    min_idx_d = min_idx_q;
    min_ls_d  = min_ls_q;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    we        = 1'b0;
    wr_ent    = ent_q;
    div_start = 1'b0;
    div_hits  = ent_q.retries;
    case (state_q)
      cqt_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          if (cmd_i.op == cqt_pkg::OP_CLEAR) begin
            used_d = '0;
          end else if (used_q == '0) begin
            state_d = cqt_pkg::ST_MISS;
          end else begin
            state_d = cqt_pkg::ST_SCAN_RD;
          end
        end
      end
      cqt_pkg::ST_SCAN_RD: state_d = cqt_pkg::ST_SCAN_CMP;
      cqt_pkg::ST_SCAN_CMP: begin
        if (rd_ent.channel == cmd_q.channel) begin
          ent_d   = rd_ent;
          eidx_d  = idx_q[AW-1:0];
          state_d = cqt_pkg::ST_ROLL;
        end else begin
          if (idx_q == '0 || rd_ent.seen_at < min_ls_q) begin
            min_ls_d  = rd_ent.seen_at;
            min_idx_d = idx_q[AW-1:0];
          end
          if (idx_q + UW'(1) == used_q) begin
            state_d = cqt_pkg::ST_MISS;
          end else begin
            idx_d   = idx_q + UW'(1);
            state_d = cqt_pkg::ST_SCAN_RD;
          end
        end
      end
      cqt_pkg::ST_MISS: begin
        if (cmd_q.op == cqt_pkg::OP_QUERY) begin
          res_d   = '{found: 1'b0, frame_count: 32'd0, retry_percent: cqt_pkg::PERCENT_NONE,
                      fcs_error_percent: cqt_pkg::PERCENT_NONE, degraded: 1'b0};
          state_d = cqt_pkg::ST_RESULT;
        end else begin
          if (used_q < UW'(TableEntries)) begin
            eidx_d = used_q[AW-1:0];
            used_d = used_q + UW'(1);
          end else begin
            eidx_d = min_idx_q;
          end
          ent_d   = '{channel: cmd_q.channel, frames: 32'd0, retries: 32'd0, fcs_errors: 32'd0,
                      win_open: cmd_q.now, seen_at: 32'd0};
          state_d = cqt_pkg::ST_ROLL;
        end
      end
      cqt_pkg::ST_ROLL: begin
        if (ent_q.win_open == 32'd0) begin
          ent_d.win_open = cmd_q.now;
        end else if (age > {16'd0, window_i}) begin
          ent_d.frames     = 32'd0;
          ent_d.retries    = 32'd0;
          ent_d.fcs_errors = 32'd0;
          ent_d.win_open   = cmd_q.now;
        end
        state_d = (cmd_q.op == cqt_pkg::OP_QUERY) ? cqt_pkg::ST_QWRITE : cqt_pkg::ST_COUNT;
      end
      cqt_pkg::ST_COUNT: begin
        if (ent_q.frames != cqt_pkg::COUNT_MAX) wr_ent.frames = ent_q.frames + 32'd1;
        if (cmd_q.retry && ent_q.retries != cqt_pkg::COUNT_MAX) begin
          wr_ent.retries = ent_q.retries + 32'd1;
        end
        if (cmd_q.fcs_error && ent_q.fcs_errors != cqt_pkg::COUNT_MAX) begin
          wr_ent.fcs_errors = ent_q.fcs_errors + 32'd1;
        end
        if (cmd_q.now > ent_q.seen_at) wr_ent.seen_at = cmd_q.now;
        we      = 1'b1;
        state_d = cqt_pkg::ST_IDLE;
      end
      cqt_pkg::ST_QWRITE: begin
        we        = 1'b1;
        div_start = 1'b1;
        state_d   = cqt_pkg::ST_DIV_R;
      end
      cqt_pkg::ST_DIV_R: begin
        if (div_done) begin
          res_d.retry_percent = pct_ok ? {1'b0, quot} : cqt_pkg::PERCENT_NONE;
          res_d.degraded      = pct_ok && (quot >= degraded_i);
          div_start = 1'b1;
          div_hits  = ent_q.fcs_errors;
          state_d   = cqt_pkg::ST_DIV_F;
        end
      end
      cqt_pkg::ST_DIV_F: begin
        div_hits = ent_q.fcs_errors;
        if (div_done) begin
          res_d.fcs_error_percent = pct_ok ? {1'b0, quot} : cqt_pkg::PERCENT_NONE;
          res_d.found             = 1'b1;
          res_d.frame_count       = ent_q.frames;
          state_d = cqt_pkg::ST_RESULT;
        end
      end
      cqt_pkg::ST_RESULT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = cqt_pkg::ST_IDLE;
        end
      end
      default: state_d = cqt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    ent_q     <= ent_d;
    res_q     <= res_d;
    idx_q     <= idx_d;
    eidx_q    <= eidx_d;
    min_idx_q <= min_idx_d;
    min_ls_q  <= min_ls_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cqt_pkg::ST_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

endmodule

>>> rtl/rf_channel_quality_table_top.sv
`timescale 1ns / 1ps
// channel   | handshake          | payload
// input     | push / full        | req_type, channel, retry_flag, fcs_error_flag, time_now
// result    | empty / pop        | found, frame_count, retry/fcs_error percent, degraded
// config    | cfg_we_i           | cfg_idx_i, cfg_data_i
// an observe or a query scans the entries in use up to a match, reading then comparing each
// entry through the table's one read port; a query then runs the 7-step divider for each percentage
// a clear only empties the table by zeroing the count of entries in use; no clearing pass follows reset
// a two-item queue on each side lets input and result stall on their own

module rf_channel_quality_table_top #(
  parameter int TableEntries = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  channel_i,
  input  logic        retry_flag_i,
  input  logic        fcs_error_flag_i,
  input  logic [31:0] time_now_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [31:0] frame_count_o,
  output logic signed [7:0] retry_percent_o,
  output logic signed [7:0] fcs_error_percent_o,
  output logic        degraded_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] window_q, min_frames_q;
  logic [6:0]  degraded_q;
  logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic        res_push, res_full;
  cqt_pkg::cmd_t    cmd_in, cmd_out;
  cqt_pkg::result_t res_in, res_out;
  logic [$bits(cqt_pkg::cmd_t)-1:0]    cmd_raw;
  logic [$bits(cqt_pkg::result_t)-1:0] res_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= cqt_pkg::WINDOW_RST;
      min_frames_q <= cqt_pkg::MIN_RST;
      degraded_q   <= cqt_pkg::DEGRADED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cqt_pkg::CFG_WINDOW:   window_q     <= cfg_data_i;
        cqt_pkg::CFG_MIN:      min_frames_q <= cfg_data_i;
        cqt_pkg::CFG_DEGRADED: degraded_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  cqt_front u_front (
    .push_i          (push),
    .full_o          (full),
    .req_type_i      (req_type_i),
    .channel_i       (channel_i),
    .retry_flag_i    (retry_flag_i),
    .fcs_error_flag_i(fcs_error_flag_i),
    .time_now_i      (time_now_i),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in),
    .cmd_full_i      (cmd_full)
  );

  cqt_fifo #(.Width($bits(cqt_pkg::cmd_t))) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_raw),
    .empty_o(cmd_empty)
  );

  assign cmd_out = cqt_pkg::cmd_t'(cmd_raw);

  cqt_back #(.TableEntries(TableEntries)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .window_i    (window_q),
    .min_frames_i(min_frames_q),
    .degraded_i  (degraded_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  cqt_fifo #(.Width($bits(cqt_pkg::result_t))) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_raw),
    .empty_o(empty)
  );

  assign res_out             = cqt_pkg::result_t'(res_raw);
  assign found_o             = res_out.found;
  assign frame_count_o       = res_out.frame_count;
  assign retry_percent_o     = res_out.retry_percent;
  assign fcs_error_percent_o = res_out.fcs_error_percent;
  assign degraded_o          = res_out.degraded;

endmodule

>>> rtl/cqt_checker.sv
`timescale 1ns / 1ps

module cqt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic              found_o,
  input logic [31:0]       frame_count_o,
  input logic signed [7:0] retry_percent_o,
  input logic signed [7:0] fcs_error_percent_o,
  input logic              degraded_o
);

  a_unknown_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |-> (frame_count_o == 32'd0 && retry_percent_o == -8'sd1 &&
                              fcs_error_percent_o == -8'sd1 && !degraded_o))
    else $error("unknown channel result not blank");

  a_degraded_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && degraded_o) |-> (retry_percent_o >= 8'sd0))
    else $error("degraded without a retry percentage");

  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((retry_percent_o <= 8'sd100 && retry_percent_o >= -8'sd1) &&
                (fcs_error_percent_o <= 8'sd100 && fcs_error_percent_o >= -8'sd1)))
    else $error("percentage out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(frame_count_o) && $stable(retry_percent_o)))
    else $error("waiting result changed");

endmodule

bind rf_channel_quality_table_top cqt_checker u_cqt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .empty              (empty),
  .pop                (pop),
  .found_o            (found_o),
  .frame_count_o      (frame_count_o),
  .retry_percent_o    (retry_percent_o),
  .fcs_error_percent_o(fcs_error_percent_o),
  .degraded_o         (degraded_o)
);
